[hw/rtl/plfm_pkg.sv]
// Shared types and constants of the price level order queue.
package plfm_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int ID_W       = 32;
  localparam int QTY_W      = 32;
  localparam int PRICE_W    = 32;
  localparam int TIME_W     = 64;
  localparam int TOTAL_W    = 36;
  localparam int SLOT_W     = ID_W + QTY_W;
  // result beat without the order count field
  localparam int RES_BASE_W = 2 + ID_W + QTY_W + PRICE_W + TIME_W + QTY_W + TOTAL_W + 1;
  localparam int RES_W_DEF  = RES_BASE_W + $clog2(DEPTH_DEF + 1);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_EXEC   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_TRADE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_SHIFT,
    ST_RESP
  } state_e;

endpackage

[hw/rtl/plfm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module plfm_ram
  import plfm_pkg::*;
#(
  parameter int WIDTH = SLOT_W,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/plfm_out_stage.sv]
// Output register that holds one result beat until the consumer takes it.
module plfm_out_stage
  import plfm_pkg::*;
#(
  parameter int WIDTH = RES_W_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             free_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/price_level_fifo_matcher.sv]
// Flow: add and clear pass from ST_IDLE to ST_RESP, which loads their one result beat into the
// output register. Execute walks ST_EXEC, one trade beat per step for at most DEPTH trades,
// or goes to ST_RESP for one ack when nothing fills. Cancel walks ST_SEARCH, one RAM read per
// entry to find the order, then ST_SHIFT, one read/write per later entry to close the gap.
// A new input beat is taken once the last result beat is loaded; a stalled result holds ST_EXEC and ST_RESP.
// Reset: empty queue, zero total and price; no clearing pass, slots are written before use.
module price_level_fifo_matcher
  import plfm_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PRICE_W-1:0]  cfg_level_price_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [ID_W-1:0]     oid_i,
  input  logic [QTY_W-1:0]    quantity_i,
  input  logic [TIME_W-1:0]   timestamp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [ID_W-1:0]     trade_oid_o,
  output logic [QTY_W-1:0]    trade_qty_o,
  output logic [PRICE_W-1:0]  trade_price_o,
  output logic [TIME_W-1:0]   trade_time_o,
  output logic [QTY_W-1:0]    filled_total_o,
  output logic [TOTAL_W-1:0]  level_total_o,
  output logic [CW-1:0]       level_count_o,
  output logic                last_o
);

  localparam int LW  = IW + 1;
  localparam int RW  = RES_BASE_W + CW;
  localparam logic [IW+1:0] DEPTH_W = (IW + 2)'(DEPTH);
  localparam logic [CW-1:0] FULL    = CW'(DEPTH);

  state_e              state_q, state_d;
  kind_e               rkind_q, rkind_d;
  logic [PRICE_W-1:0]  price_q, price_d;
  logic [CW-1:0]       count_q, count_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [IW-1:0]       head_q, head_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [QTY_W-1:0]    filled_q, filled_d;
  logic [ID_W-1:0]     id_q;
  logic [QTY_W-1:0]    qty_q;
  logic [TIME_W-1:0]   ts_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]   ram_wdata, ram_rdata;
  logic [ID_W-1:0]     rd_id;
  logic [QTY_W-1:0]    rd_rem;

  logic                in_fire;
  logic                out_load, out_free;
  logic [RW-1:0]       res_data, out_data;
  kind_e               r_kind;
  logic [ID_W-1:0]     r_id;
  logic [QTY_W-1:0]    r_qty;
  logic [PRICE_W-1:0]  r_price;
  logic [TIME_W-1:0]   r_time;
  logic [QTY_W-1:0]    r_filled;
  logic                r_last;

  logic [QTY_W-1:0]    want, fill, fill_sum;
  logic                retire, done;
  logic [LW-1:0]       idx_p1, idx_p2;
  logic                match;

  // logical queue position to RAM address, head-relative with one wrap
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [LW-1:0] off);
    logic [IW+1:0] s;
    s = {2'b00, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IW-1:0];
  endfunction

  assign rd_id  = ram_rdata[SLOT_W-1 -: ID_W];
  assign rd_rem = ram_rdata[QTY_W-1:0];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign want     = qty_q - filled_q;
  assign retire   = (rd_rem <= want);
  assign fill     = retire ? rd_rem : want;
  assign fill_sum = filled_q + fill;
  assign done     = (fill_sum == qty_q) || (retire && (count_q == CW'(1)));
  assign idx_p1   = {1'b0, idx_q} + LW'(1);
  assign idx_p2   = {1'b0, idx_q} + LW'(2);
  assign match    = (rd_id == id_q);

  always_comb begin
    state_d   = state_q;
    rkind_d   = rkind_q;
    price_d   = price_q;
    count_d   = count_q;
    total_d   = total_q;
    head_d    = head_q;
    idx_d     = idx_q;
    filled_d  = filled_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = ram_rdata;
    ram_raddr = head_q;
    out_load  = 1'b0;
    r_kind    = KIND_ACK;
    r_id      = '0;
    r_qty     = '0;
    r_price   = '0;
    r_time    = '0;
    r_filled  = '0;
    r_last    = 1'b1;

    if (cfg_valid_i) begin
      price_d = cfg_level_price_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RESP;
          case (func_e'(func_i))
            FUNC_ADD: begin
              if (count_q == FULL) begin
                rkind_d = KIND_ERROR;
              end else begin
                rkind_d   = KIND_ACK;
                ram_we    = 1'b1;
                ram_waddr = phys(head_q, LW'(count_q));
                ram_wdata = {oid_i, quantity_i};
                count_d   = count_q + CW'(1);
                total_d   = total_q + {{(TOTAL_W - QTY_W){1'b0}}, quantity_i};
              end
            end
            FUNC_CANCEL: begin
              idx_d = '0;
              if (count_q == '0) begin
                rkind_d = KIND_ERROR;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            FUNC_EXEC: begin
              filled_d = '0;
              rkind_d  = KIND_ACK;
              if (count_q != '0 && quantity_i != '0) begin
                state_d = ST_EXEC;
              end
            end
            default: begin
              // clear level
              rkind_d = KIND_ACK;
              count_d = '0;
              total_d = '0;
              head_d  = '0;
              price_d = '0;
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          r_kind   = KIND_TRADE;
          r_id     = rd_id;
          r_qty    = fill;
          r_price  = price_q;
          r_time   = ts_q;
          r_filled = fill_sum;
          r_last   = done;
          filled_d = fill_sum;
          total_d  = total_q - {{(TOTAL_W - QTY_W){1'b0}}, fill};
          if (retire) begin
            // retire head order and prefetch the next one
            head_d    = phys(head_q, LW'(1));
            count_d   = count_q - CW'(1);
            ram_raddr = head_d;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_q;
            ram_wdata = {rd_id, rd_rem - fill};
          end
          if (done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        ram_raddr = phys(head_q, idx_p1);
        if (match) begin
          total_d = total_q - {{(TOTAL_W - QTY_W){1'b0}}, rd_rem};
          if (idx_p1 == LW'(count_q)) begin
            count_d = count_q - CW'(1);
            rkind_d = KIND_ACK;
            state_d = ST_RESP;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (idx_p1 == LW'(count_q)) begin
          rkind_d = KIND_ERROR;
          state_d = ST_RESP;
        end else begin
          idx_d = idx_p1[IW-1:0];
        end
      end
      ST_SHIFT: begin
        // move entry idx+1 down to idx, prefetch idx+2
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, {1'b0, idx_q});
        ram_wdata = ram_rdata;
        ram_raddr = phys(head_q, idx_p2);
        idx_d     = idx_p1[IW-1:0];
        if (idx_p2 == LW'(count_q)) begin
          count_d = count_q - CW'(1);
          rkind_d = KIND_ACK;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          r_kind   = rkind_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rkind_q  <= KIND_ACK;
      price_q  <= '0;
      count_q  <= '0;
      total_q  <= '0;
      head_q   <= '0;
      idx_q    <= '0;
      filled_q <= '0;
    end else begin
      state_q  <= state_d;
      rkind_q  <= rkind_d;
      price_q  <= price_d;
      count_q  <= count_d;
      total_q  <= total_d;
      head_q   <= head_d;
      idx_q    <= idx_d;
      filled_q <= filled_d;
    end
  end

  // hold the accepted beat's payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q  <= oid_i;
      qty_q <= quantity_i;
      ts_q  <= timestamp_i;
    end
  end

  plfm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_data = {r_kind, r_id, r_qty, r_price, r_time, r_filled, total_d, count_d, r_last};

  plfm_out_stage #(
    .WIDTH (RW)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (res_data),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data),
    .free_o  (out_free)
  );

  assign {kind_o, trade_oid_o, trade_qty_o, trade_price_o, trade_time_o,
          filled_total_o, level_total_o, level_count_o, last_o} = out_data;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("order count above queue depth");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> total_q == '0)
    else $error("empty level with nonzero resting total");

  a_exec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> count_q != '0)
    else $error("execute walk on an empty queue");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> {1'b0, idx_q} < LW'(count_q))
    else $error("search index beyond queue tail");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT |-> idx_p1 < LW'(count_q))
    else $error("shift source beyond queue tail");
`endif

endmodule

[tb/sv/price_level_fifo_matcher_tb.sv]
// Testbench of the price level order queue: table and random beats checked against a predictor.
module price_level_fifo_matcher_tb;
  import plfm_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = DEPTH + 4;
  localparam int N_ROWS      = 15;
  localparam int N_PHASES    = 4;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    kind_e              kind;
    logic [ID_W-1:0]    oid;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  stamp;
    logic [QTY_W-1:0]   filled;
    logic [TOTAL_W-1:0] total;
    logic [CW-1:0]      count;
    logic               last;
  } beat_t;

  typedef struct {
    func_e              op;
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
    logic [TIME_W-1:0]  stamp;
    int unsigned        rep;
    bit                 typed;
    kind_e              kind;
    logic [TOTAL_W-1:0] total;
    logic [CW-1:0]      count;
  } step_row_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_valid_i       = 1'b0;
  logic               cfg_ready_o;
  logic [PRICE_W-1:0] cfg_level_price_i = '0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i            = '0;
  logic [ID_W-1:0]    oid_i             = '0;
  logic [QTY_W-1:0]   quantity_i        = '0;
  logic [TIME_W-1:0]  timestamp_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic [1:0]         kind_o;
  logic [ID_W-1:0]    trade_oid_o;
  logic [QTY_W-1:0]   trade_qty_o;
  logic [PRICE_W-1:0] trade_price_o;
  logic [TIME_W-1:0]  trade_time_o;
  logic [QTY_W-1:0]   filled_total_o;
  logic [TOTAL_W-1:0] level_total_o;
  logic [CW-1:0]      level_count_o;
  logic               last_o;

  always #6 clk_i = ~clk_i;

  price_level_fifo_matcher DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_level_price_i (cfg_level_price_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .oid_i             (oid_i),
    .quantity_i        (quantity_i),
    .timestamp_i       (timestamp_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .trade_oid_o       (trade_oid_o),
    .trade_qty_o       (trade_qty_o),
    .trade_price_o     (trade_price_o),
    .trade_time_o      (trade_time_o),
    .filled_total_o    (filled_total_o),
    .level_total_o     (level_total_o),
    .level_count_o     (level_count_o),
    .last_o            (last_o)
  );

  // Shadow copy of the price level
  logic [ID_W-1:0]    slot_id  [DEPTH];
  logic [QTY_W-1:0]   slot_rem [DEPTH];
  int unsigned        resting       = 0;
  logic [TOTAL_W-1:0] resting_total = '0;
  logic [PRICE_W-1:0] book_price    = '0;

  beat_t       pending_beats[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;

  function automatic beat_t make_beat(kind_e kind, logic [TOTAL_W-1:0] total,
                                      logic [CW-1:0] count);
    beat_t b;
    b.kind     = kind;
    b.oid      = '0;
    b.qty      = '0;
    b.price    = '0;
    b.stamp    = '0;
    b.filled   = '0;
    b.total    = total;
    b.count    = count;
    b.last     = 1'b1;
    return b;
  endfunction

  // Close the gap left by a removed order
  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < resting; i++) begin
      slot_id[i]  = slot_id[i + 1];
      slot_rem[i] = slot_rem[i + 1];
    end
    if (resting > 0) resting--;
  endfunction

  function automatic void predict_level(func_e op, logic [ID_W-1:0] id,
                                        logic [QTY_W-1:0] qty, logic [TIME_W-1:0] stamp,
                                        ref beat_t beats[$]);
    int unsigned      pos;
    int unsigned      n;
    logic [QTY_W-1:0] filled;
    logic [QTY_W-1:0] fill;
    logic [QTY_W-1:0] want;
    logic [ID_W-1:0]  who;
    beat_t            b;
    case (op)
      FUNC_ADD: begin
        if (resting >= DEPTH) begin
          beats.insert(beats.size(), make_beat(KIND_ERROR, resting_total, CW'(resting)));
        end else begin
          slot_id[resting]  = id;
          slot_rem[resting] = qty;
          resting++;
          resting_total = resting_total + TOTAL_W'(qty);
          beats.insert(beats.size(), make_beat(KIND_ACK, resting_total, CW'(resting)));
        end
      end
      FUNC_CANCEL: begin
        pos = 0;
        while (pos < resting && slot_id[pos] != id) pos++;
        if (pos >= resting) begin
          beats.insert(beats.size(), make_beat(KIND_ERROR, resting_total, CW'(resting)));
        end else begin
          resting_total = resting_total - TOTAL_W'(slot_rem[pos]);
          drop_slot(pos);
          beats.insert(beats.size(), make_beat(KIND_ACK, resting_total, CW'(resting)));
        end
      end
      FUNC_EXEC: begin
        filled = '0;
        n      = 0;
        while (resting > 0 && filled < qty && n < DEPTH) begin
          want          = qty - filled;
          fill          = (slot_rem[0] < want) ? slot_rem[0] : want;
          who           = slot_id[0];
          slot_rem[0]   = slot_rem[0] - fill;
          resting_total = resting_total - TOTAL_W'(fill);
          filled        = filled + fill;
          if (slot_rem[0] == '0) drop_slot(0);
          b          = make_beat(KIND_TRADE, resting_total, CW'(resting));
          b.oid      = who;
          b.qty      = fill;
          b.price    = book_price;
          b.stamp    = stamp;
          b.filled   = filled;
          b.last     = 1'b0;
          beats.insert(beats.size(), b);
          n++;
        end
        if (n == 0) begin
          beats.insert(beats.size(), make_beat(KIND_ACK, resting_total, CW'(resting)));
        end else begin
          b      = beats.pop_back();
          b.last = 1'b1;
          beats.insert(beats.size(), b);
        end
      end
      default: begin
        // clear level
        resting       = 0;
        resting_total = '0;
        book_price    = '0;
        beats.insert(beats.size(), make_beat(KIND_ACK, resting_total, CW'(resting)));
      end
    endcase
  endfunction

  task automatic write_price(logic [PRICE_W-1:0] price);
    bit took;
    cfg_valid_i       <= 1'b1;
    cfg_level_price_i <= price;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = (cfg_ready_o === 1'b1);
      if (took) book_price = price;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic issue(func_e op, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty,
                       logic [TIME_W-1:0] stamp, bit typed, beat_t typed_beat);
    int unsigned gap;
    bit          took;
    beat_t       beats[$];
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    func_i      <= op;
    oid_i       <= id;
    quantity_i  <= qty;
    timestamp_i <= stamp;
    took = 1'b0;
    while (!took) begin
      // inputs only move at the rising edge, so the falling edge sees the handshake settled
      @(negedge clk_i);
      took = (in_ready_o === 1'b1);
      if (took) begin
        predict_level(op, id, qty, stamp, beats);
        if (typed) pending_beats.insert(pending_beats.size(), typed_beat);
        else foreach (beats[j]) pending_beats.insert(pending_beats.size(), beats[j]);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic issue_random();
    int unsigned       r;
    int unsigned       add_weight;
    func_e             op;
    logic [ID_W-1:0]   id;
    logic [QTY_W-1:0]  qty;
    logic [TIME_W-1:0] stamp;
    beat_t             none;
    r          = $urandom_range(0, 99);
    add_weight = (resting < 4) ? 55 : ((resting >= DEPTH) ? 12 : 35);
    // small id pool gives duplicates and cancel hits
    id    = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 31) : $urandom();
    qty   = $urandom();
    stamp = {$urandom(), $urandom()};
    if ($urandom_range(0, 19) == 0) stamp = $urandom_range(0, 1) ? '1 : '0;
    if (r < 3) begin
      op = FUNC_CLEAR;
    end else if (r < 3 + add_weight) begin
      op = FUNC_ADD;
      case ($urandom_range(0, 9))
        0:       qty = '0;
        1, 2:    qty = $urandom();
        default: qty = $urandom_range(1, 50);
      endcase
    end else if (r < 28 + add_weight) begin
      op = FUNC_CANCEL;
      if (resting > 0 && $urandom_range(0, 4) != 0) id = slot_id[$urandom_range(0, resting - 1)];
    end else begin
      op = FUNC_EXEC;
      case ($urandom_range(0, 9))
        0:       qty = '0;
        1:       qty = $urandom();
        2, 3:    qty = $urandom_range(1, 400);
        default: qty = $urandom_range(1, 60);
      endcase
    end
    issue(op, id, qty, stamp, 1'b0, none);
  endtask

  // Hold the sender until the level is idle
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    beat_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t result beat with nothing expected, kind %h", $time, kind_o);
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("trade_oid", want.oid, trade_oid_o);
        check_field("trade_qty", want.qty, trade_qty_o);
        check_field("trade_price", want.price, trade_price_o);
        check_field("trade_time", want.stamp, trade_time_o);
        check_field("filled_total", want.filled, filled_total_o);
        check_field("level_total", want.total, level_total_o);
        check_field("level_count", want.count, level_count_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Receiver stalls on a rotating mask, reloaded now and then
  logic [15:0] stall_mask = 16'hFFFF;
  int unsigned stall_age  = 0;

  always @(posedge clk_i) begin
    stall_age <= stall_age + 1;
    if (stall_age % 96 == 95) begin
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0101);
    end else begin
      stall_mask <= {stall_mask[14:0], stall_mask[15]};
    end
    out_ready_i <= stall_mask[0];
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    step_row_t          script [N_ROWS];
    logic [PRICE_W-1:0] price;
    script = '{
      '{FUNC_EXEC,   32'h0,        32'd5,        64'h0,  1, 1'b1, KIND_ACK,   36'h0, 0},
      '{FUNC_CANCEL, 32'd7,        32'd0,        64'h0,  1, 1'b1, KIND_ERROR, 36'h0, 0},
      '{FUNC_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 64'h0,  1, 1'b1, KIND_ACK,
        36'hFFFFFFFF, 1},
      '{FUNC_ADD,    32'h0,        32'h0,        64'h0,  1, 1'b1, KIND_ACK,
        36'hFFFFFFFF, 2},
      '{FUNC_ADD,    32'd5,        32'd10,       64'h0,  1, 1'b0, KIND_ACK,   36'h0, 0},
      '{FUNC_ADD,    32'd5,        32'd20,       64'h0,  1, 1'b0, KIND_ACK,   36'h0, 0},
      '{FUNC_CANCEL, 32'd5,        32'd0,        64'h0,  1, 1'b0, KIND_ACK,   36'h0, 0},
      '{FUNC_EXEC,   32'h0,        32'd0,        64'hA5A5_5A5A_0F0F_F0F0, 1, 1'b0,
        KIND_ACK, 36'h0, 0},
      '{FUNC_EXEC,   32'h0,        32'hFFFFFFFF, '1,     1, 1'b0, KIND_ACK,   36'h0, 0},
      '{FUNC_EXEC,   32'h0,        32'd1,        64'd1,  1, 1'b0, KIND_ACK,   36'h0, 0},
      '{FUNC_CANCEL, 32'hFFFFFFFF, 32'd0,        64'h0,  1, 1'b1, KIND_ERROR, 36'd19, 1},
      '{FUNC_CLEAR,  32'h0,        32'h0,        64'h0,  1, 1'b1, KIND_ACK,   36'h0, 0},
      '{FUNC_ADD,    32'h100,      32'd1,        64'h0,  DEPTH, 1'b0, KIND_ACK, 36'h0, 0},
      '{FUNC_ADD,    32'hDEAD,     32'd9,        64'h0,  1, 1'b1, KIND_ERROR,
        36'd16, 16},
      '{FUNC_EXEC,   32'h0,        32'hFFFFFFFF, 64'h0123_4567_89AB_CDEF, 1, 1'b0,
        KIND_ACK, 36'h0, 0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_price(32'h8000_0001);
    foreach (script[k]) begin
      for (int unsigned r = 0; r < script[k].rep; r++) begin
        issue(script[k].op, script[k].id + r, script[k].qty, script[k].stamp,
              script[k].typed, make_beat(script[k].kind, script[k].total, script[k].count));
      end
    end
    hold_until_drained();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       price = '1;
        1:       price = '0;
        default: price = $urandom();
      endcase
      write_price(price);
      no_gaps = (ph == 2);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == PHASE_ITEMS / 2) hold_until_drained();
        issue_random();
      end
      hold_until_drained();
    end

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
